[rtl/jbt_pkg.sv]
package jbt_pkg;

   localparam int MAX_DEPTH_DEF   = 32;
   localparam int OFFSET_BITS_DEF = 32;

   typedef enum logic [3:0] {
      PH_START     = 4'd0,
      PH_KEY       = 4'd1,
      PH_KEY_END   = 4'd2,
      PH_VALUE     = 4'd3,
      PH_STR       = 4'd4,
      PH_NUM       = 4'd5,
      PH_LIT       = 4'd6,
      PH_VALUE_END = 4'd7,
      PH_END       = 4'd8,
      PH_ERR       = 4'd9
   } phase_type;

   typedef enum logic [3:0] {
      TK_OBJ_BEGIN = 4'd0,
      TK_OBJ_END   = 4'd1,
      TK_ARR_BEGIN = 4'd2,
      TK_ARR_END   = 4'd3,
      TK_STRING    = 4'd4,
      TK_NUMBER    = 4'd5,
      TK_TRUE      = 4'd6,
      TK_FALSE     = 4'd7,
      TK_NULL      = 4'd8,
      TK_COLON     = 4'd9,
      TK_COMMA     = 4'd10
   } tok_type;

   typedef enum logic [2:0] {
      ERR_OK       = 3'd0,
      ERR_UNEXP    = 3'd1,
      ERR_EMPTYKEY = 3'd2,
      ERR_LITERAL  = 3'd3,
      ERR_DEEP     = 3'd4,
      ERR_EARLY    = 3'd5
   } err_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] start;
      logic [31:0] stop;
      logic [2:0]  err;
      logic        done;
      logic        last;
   } tok_rec_type;

   function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      unique case (kind)
         2'd0: begin
            unique case (idx)
               3'd0: c = "t";
               3'd1: c = "r";
               3'd2: c = "u";
               3'd3: c = "e";
               default: c = 8'h00;
            endcase
         end
         2'd1: begin
            unique case (idx)
               3'd0: c = "f";
               3'd1: c = "a";
               3'd2: c = "l";
               3'd3: c = "s";
               3'd4: c = "e";
               default: c = 8'h00;
            endcase
         end
         2'd2: begin
            unique case (idx)
               3'd0: c = "n";
               3'd1: c = "u";
               3'd2: c = "l";
               3'd3: c = "l";
               default: c = 8'h00;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] lit_len(input logic [1:0] kind);
      return (kind == 2'd1) ? 3'd5 : 3'd4;
   endfunction

endpackage

[rtl/jbt_front.sv]
module jbt_front import jbt_pkg::*; #(
   parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_byte,
   input  logic        q_room,
   output logic        q_push,
   output logic [1:0]  q_count,
   output tok_rec_type q_rec0,
   output tok_rec_type q_rec1
);

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   phase_type              phase_ff, phase_in;
   logic [DW-1:0]          depth_ff, depth_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in, begin_ff, begin_in, off1;
   logic [1:0]             lkind_ff, lkind_in;
   logic [2:0]             lidx_ff, lidx_in;
   logic                   iskey_ff, iskey_in;
   logic                   top_ff, top_in;
   logic [MAX_DEPTH-1:0]   kinds_ff;
   logic                   wr_en, pop_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic                   wr_val;

   tok_rec_type r [3];
   logic [1:0]  n;
   logic        acc;
   logic [7:0]  c;
   logic        ws, digit;
   phase_type   sp;

   assign acc       = req_valid && q_room;
   assign req_stall = !q_room;
   assign c         = req_char_in;
   assign off1      = off_ff + 1'b1;
   assign ws        = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   assign digit     = (c >= "0") && (c <= "9");

   // Top-of-stack kind has its own register so comma and close checks read no array.
   always_ff @(posedge clock) begin
      if (wr_en) kinds_ff[wr_addr] <= wr_val;
   end

   always_comb begin
      tok_rec_type t;
      phase_type   p;
      logic        failed;
      logic        num_emit;
      t = '0;
      for (int i = 0; i < 3; i++) r[i] = '0;
      n = 2'd0;
      phase_in = phase_ff;
      depth_in = depth_ff;
      off_in = off1;
      begin_in = begin_ff;
      lkind_in = lkind_ff;
      lidx_in = lidx_ff;
      iskey_in = iskey_ff;
      top_in = top_ff;
      wr_en = 1'b0;
      wr_addr = depth_ff[AW-1:0];
      wr_val = 1'b0;
      pop_en = 1'b0;
      rd_addr = '0;
      failed = 1'b0;
      num_emit = 1'b0;
      p = phase_ff;
      sp = phase_ff;

      t.start = 32'(off_ff);
      t.stop  = 32'(off1);

      unique case (phase_ff)
         PH_ERR: ;
         PH_STR: begin
            if (c == "\"") begin
               if (iskey_ff && off_ff == begin_ff + 1'b1) begin
                  failed = 1'b1;
                  t.err = ERR_EMPTYKEY;
               end else begin
                  r[0] = '0;
                  r[0].kind = TK_STRING;
                  r[0].start = 32'(begin_ff);
                  r[0].stop = 32'(off1);
                  n = 2'd1;
                  p = iskey_ff ? PH_KEY_END : PH_VALUE_END;
               end
            end
         end
         PH_LIT: begin
            if (c != lit_char(lkind_ff, lidx_ff) || lkind_ff == 2'd3) begin
               failed = 1'b1;
               t.err = ERR_LITERAL;
            end else begin
               lidx_in = lidx_ff + 3'd1;
               if (lidx_in == lit_len(lkind_ff)) begin
                  r[0] = '0;
                  r[0].kind = 4'(6 + lkind_ff);
                  r[0].start = 32'(begin_ff);
                  r[0].stop = 32'(off1);
                  n = 2'd1;
                  p = PH_VALUE_END;
               end
            end
         end
         default: begin
            if (phase_ff == PH_NUM) begin
               if (!digit) begin
                  r[0] = '0;
                  r[0].kind = TK_NUMBER;
                  r[0].start = 32'(begin_ff);
                  r[0].stop = 32'(off_ff);
                  n = 2'd1;
                  sp = PH_VALUE_END;
                  p = PH_VALUE_END;
                  num_emit = 1'b1;
               end
            end
            if ((phase_ff != PH_NUM || num_emit) && !ws) begin
               priority case (sp)
                  PH_START, PH_VALUE: begin
                     if (sp == PH_VALUE) begin_in = off_ff;
                     if (c == "{" || c == "[") begin
                        if (depth_ff >= DW'(MAX_DEPTH)) begin
                           failed = 1'b1;
                           t.err = ERR_DEEP;
                        end else begin
                           wr_en = 1'b1;
                           wr_val = (c == "[");
                           top_in = wr_val;
                           depth_in = depth_ff + 1'b1;
                           r[n] = '0;
                           r[n].kind = wr_val ? TK_ARR_BEGIN : TK_OBJ_BEGIN;
                           r[n].start = 32'(off_ff);
                           r[n].stop = 32'(off1);
                           n = n + 2'd1;
                           p = wr_val ? PH_VALUE : PH_KEY;
                        end
                     end else if (sp == PH_VALUE && c == "\"") begin
                        iskey_in = 1'b0;
                        p = PH_STR;
                     end else if (sp == PH_VALUE && digit) begin
                        p = PH_NUM;
                     end else if (sp == PH_VALUE && (c == "t" || c == "f" || c == "n")) begin
                        lkind_in = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
                        lidx_in = 3'd1;
                        p = PH_LIT;
                     end else begin
                        failed = 1'b1;
                        t.err = ERR_UNEXP;
                     end
                  end
                  PH_KEY: begin
                     if (c == "\"") begin
                        begin_in = off_ff;
                        iskey_in = 1'b1;
                        p = PH_STR;
                     end else begin
                        failed = 1'b1;
                        t.err = ERR_UNEXP;
                     end
                  end
                  PH_KEY_END: begin
                     if (c == ":") begin
                        r[n] = '0;
                        r[n].kind = TK_COLON;
                        r[n].start = 32'(off_ff);
                        r[n].stop = 32'(off1);
                        n = n + 2'd1;
                        p = PH_VALUE;
                     end else begin
                        failed = 1'b1;
                        t.err = ERR_UNEXP;
                     end
                  end
                  PH_VALUE_END: begin
                     if (c == "," && depth_ff != '0) begin
                        r[n] = '0;
                        r[n].kind = TK_COMMA;
                        r[n].start = 32'(off_ff);
                        r[n].stop = 32'(off1);
                        n = n + 2'd1;
                        p = top_ff ? PH_VALUE : PH_KEY;
                     end else if ((c == "}" || c == "]") && depth_ff != '0
                                  && top_ff == (c == "]")) begin
                        depth_in = depth_ff - 1'b1;
                        pop_en = 1'b1;
                        r[n] = '0;
                        r[n].kind = (c == "]") ? TK_ARR_END : TK_OBJ_END;
                        r[n].start = 32'(off_ff);
                        r[n].stop = 32'(off1);
                        r[n].done = (depth_in == '0);
                        n = n + 2'd1;
                        p = (depth_in == '0) ? PH_END : PH_VALUE_END;
                     end else begin
                        failed = 1'b1;
                        t.err = ERR_UNEXP;
                     end
                  end
                  default: begin
                     failed = 1'b1;
                     t.err = ERR_UNEXP;
                  end
               endcase
            end
         end
      endcase

      if (failed) begin
         t.kind = TK_OBJ_BEGIN;
         t.done = 1'b1;
         r[n] = t;
         n = n + 2'd1;
         p = PH_ERR;
      end

      if (pop_en) begin
         rd_addr = AW'(depth_ff - 2'd2);
         top_in = (depth_ff >= DW'(2)) ? kinds_ff[rd_addr] : 1'b0;
      end

      phase_in = p;

      if (req_last_byte) begin
         if (p == PH_NUM) begin
            r[n] = '0;
            r[n].kind = TK_NUMBER;
            r[n].start = 32'(begin_in);
            r[n].stop = 32'(off1);
            n = n + 2'd1;
         end
         if (p != PH_END && p != PH_ERR) begin
            if (n >= 2'd2) n = 2'd1;
            r[n] = '0;
            r[n].kind = TK_OBJ_BEGIN;
            r[n].start = 32'(off_ff);
            r[n].stop = 32'(off1);
            r[n].err = ERR_EARLY;
            r[n].done = 1'b1;
            n = n + 2'd1;
         end
         phase_in = PH_START;
         depth_in = '0;
         off_in = '0;
         begin_in = '0;
         lkind_in = '0;
         lidx_in = '0;
         iskey_in = 1'b0;
         top_in = 1'b0;
      end
      if (n > 2'd2) n = 2'd2;
      if (n == 2'd1) r[0].last = 1'b1;
      if (n == 2'd2) r[1].last = 1'b1;
      if (!acc) wr_en = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         depth_ff <= '0;
         off_ff   <= '0;
         begin_ff <= '0;
         lkind_ff <= '0;
         lidx_ff  <= '0;
         iskey_ff <= 1'b0;
         top_ff   <= 1'b0;
      end else if (acc) begin
         phase_ff <= phase_in;
         depth_ff <= depth_in;
         off_ff   <= off_in;
         begin_ff <= begin_in;
         lkind_ff <= lkind_in;
         lidx_ff  <= lidx_in;
         iskey_ff <= iskey_in;
         top_ff   <= top_in;
      end
   end

   assign q_push  = acc && (n != 2'd0);
   assign q_count = n;
   assign q_rec0  = r[0];
   assign q_rec1  = r[1];

   always_ff @(posedge clock) begin
      if (!reset) begin
         assert (depth_ff <= DW'(MAX_DEPTH)) else $error("stack depth overflow");
      end
   end

   property p_err_empty;
      @(posedge clock) disable iff (reset)
         (phase_ff == PH_ERR) |-> !q_push;
   endproperty
   a_err_empty: assert property (p_err_empty) else $error("beat produced in error phase");

   property p_start_depth;
      @(posedge clock) disable iff (reset)
         (phase_ff == PH_START) |-> (depth_ff == '0);
   endproperty
   a_start_depth: assert property (p_start_depth) else $error("start with open stack");

   property p_last_reset;
      @(posedge clock) disable iff (reset)
         (acc && req_last_byte) |=> (phase_ff == PH_START && off_ff == '0);
   endproperty
   a_last_reset: assert property (p_last_reset) else $error("no reset after last byte");

endmodule

[rtl/jbt_back.sv]
module jbt_back import jbt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_push,
   input  logic [1:0]  q_count,
   input  tok_rec_type q_rec0,
   input  tok_rec_type q_rec1,
   output logic        q_room,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output tok_rec_type rsp_rec
);

   localparam int DEPTH = 4;

   tok_rec_type    mem_ff [DEPTH];
   logic [1:0]     wp_ff, rp_ff;
   logic [2:0]     cnt_ff, cnt_in;
   logic           pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_rec   = mem_ff[rp_ff];
   assign q_room    = (cnt_ff <= 3'd2);

   always_comb begin
      cnt_in = cnt_ff - {2'b0, pop} + (q_push ? {1'b0, q_count} : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wp_ff] <= q_rec0;
         if (q_count == 2'd2) mem_ff[wp_ff + 2'd1] <= q_rec1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (q_push) wp_ff <= wp_ff + q_count;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_in;
      end
   end

   property p_no_over;
      @(posedge clock) disable iff (reset) cnt_ff <= 3'(DEPTH);
   endproperty
   a_no_over: assert property (p_no_over) else $error("queue overflow");

   property p_push_room;
      @(posedge clock) disable iff (reset) q_push |-> q_room;
   endproperty
   a_push_room: assert property (p_push_room) else $error("push without room");

   property p_hold;
      @(posedge clock) disable iff (reset) (rsp_valid && rsp_stall) |=> rsp_valid;
   endproperty
   a_hold: assert property (p_hold) else $error("stalled beat dropped");

endmodule

[rtl/json_byte_tokenizer_top.sv]
// A byte's beats enter the result queue as it is accepted and leave in order.
// Bytes in and beats out go one per cycle unless stalled; a byte yields up to two beats.
// Input stalls only while the four-entry result queue has fewer than two free slots.
// Reset is synchronous and active high; it clears phase, depth, offsets and the queue.
module json_byte_tokenizer_top import jbt_pkg::*; #(
   parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [31:0] rsp_token_start,
   output logic [31:0] rsp_token_end,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_doc_done,
   output logic        rsp_run_last
);

   logic        q_room, q_push;
   logic [1:0]  q_count;
   tok_rec_type q_rec0, q_rec1, rec;

   jbt_front #(.MAX_DEPTH(MAX_DEPTH), .OFFSET_BITS(OFFSET_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_char_in, .req_last_byte,
      .q_room, .q_push, .q_count, .q_rec0, .q_rec1
   );

   jbt_back u_back (
      .clock, .reset, .q_push, .q_count, .q_rec0, .q_rec1, .q_room,
      .rsp_valid, .rsp_stall, .rsp_rec(rec)
   );

   assign rsp_token_kind  = rec.kind;
   assign rsp_token_start = rec.start;
   assign rsp_token_end   = rec.stop;
   assign rsp_error_code  = rec.err;
   assign rsp_doc_done    = rec.done;
   assign rsp_run_last    = rec.last;

endmodule

[sim/tb_checker.sv]
`timescale 1ns / 1ps

module tb_checker import jbt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_token_kind,
   input  logic [31:0] rsp_token_start,
   input  logic [31:0] rsp_token_end,
   input  logic [2:0]  rsp_error_code,
   input  logic        rsp_doc_done,
   input  logic        rsp_run_last,
   output int          fail_count,
   output int          pending_tokens
);

   localparam int DEPTH = 32;

   phase_type   phase;
   logic        kinds [DEPTH];
   int          depth;
   logic [31:0] offset;
   logic [31:0] tok_begin;
   logic [1:0]  lit_kind;
   logic [2:0]  lit_idx;
   logic        is_key;

   tok_rec_type token_q[$];
   tok_rec_type step_toks[$];

   assign pending_tokens = token_q.size();

   task automatic report(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic void emit(input tok_type k, input logic [31:0] s, input logic [31:0] e,
                                input err_type er, input logic d);
      tok_rec_type t;
      t.kind = k;
      t.start = s;
      t.stop = e;
      t.err = er;
      t.done = d;
      t.last = 1'b0;
      if (step_toks.size() < 3) step_toks.push_back(t);
   endfunction

   function automatic void raise_error(input err_type er, input logic [31:0] off);
      emit(TK_OBJ_BEGIN, off, off + 1, er, 1'b1);
      phase = PH_ERR;
   endfunction

   function automatic bit blank(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic logic [7:0] lit_byte(input logic [1:0] k, input logic [2:0] i);
      string s;
      s = (k == 0) ? "true" : (k == 1) ? "false" : "null";
      return (i < s.len()) ? s[i] : 8'h00;
   endfunction

   function automatic void open_one(input logic arr, input logic [31:0] off);
      if (depth >= DEPTH) begin
         raise_error(ERR_DEEP, off);
         return;
      end
      kinds[depth] = arr;
      depth++;
      emit(arr ? TK_ARR_BEGIN : TK_OBJ_BEGIN, off, off + 1, ERR_OK, 1'b0);
      phase = arr ? PH_VALUE : PH_KEY;
   endfunction

   function automatic void close_one(input logic arr, input logic [31:0] off);
      if (depth == 0 || kinds[depth-1] != arr) begin
         raise_error(ERR_UNEXP, off);
         return;
      end
      depth--;
      emit(arr ? TK_ARR_END : TK_OBJ_END, off, off + 1, ERR_OK, depth == 0);
      phase = (depth == 0) ? PH_END : PH_VALUE_END;
   endfunction

   function automatic void scan_structure(input logic [7:0] c, input logic [31:0] off);
      if (phase == PH_ERR || blank(c)) return;
      case (phase)
         PH_START: begin
            if (c == "{") open_one(1'b0, off);
            else if (c == "[") open_one(1'b1, off);
            else raise_error(ERR_UNEXP, off);
         end
         PH_KEY: begin
            if (c == "\"") begin
               tok_begin = off;
               is_key = 1'b1;
               phase = PH_STR;
            end else raise_error(ERR_UNEXP, off);
         end
         PH_KEY_END: begin
            if (c == ":") begin
               emit(TK_COLON, off, off + 1, ERR_OK, 1'b0);
               phase = PH_VALUE;
            end else raise_error(ERR_UNEXP, off);
         end
         PH_VALUE: begin
            tok_begin = off;
            if (c == "{") open_one(1'b0, off);
            else if (c == "[") open_one(1'b1, off);
            else if (c == "\"") begin
               is_key = 1'b0;
               phase = PH_STR;
            end else if (c >= "0" && c <= "9") phase = PH_NUM;
            else if (c == "t" || c == "f" || c == "n") begin
               lit_kind = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
               lit_idx = 3'd1;
               phase = PH_LIT;
            end else raise_error(ERR_UNEXP, off);
         end
         PH_VALUE_END: begin
            if (c == ",") begin
               if (depth == 0) raise_error(ERR_UNEXP, off);
               else begin
                  emit(TK_COMMA, off, off + 1, ERR_OK, 1'b0);
                  phase = kinds[depth-1] ? PH_VALUE : PH_KEY;
               end
            end else if (c == "}") close_one(1'b0, off);
            else if (c == "]") close_one(1'b1, off);
            else raise_error(ERR_UNEXP, off);
         end
         default: raise_error(ERR_UNEXP, off);
      endcase
   endfunction

   function automatic void tokenize_byte(input logic [7:0] c, input logic fin);
      logic [31:0] off;
      off = offset;
      step_toks.delete();
      case (phase)
         PH_ERR: ;
         PH_STR: begin
            if (c == "\"") begin
               if (is_key && off == tok_begin + 1) raise_error(ERR_EMPTYKEY, off);
               else begin
                  emit(TK_STRING, tok_begin, off + 1, ERR_OK, 1'b0);
                  phase = is_key ? PH_KEY_END : PH_VALUE_END;
               end
            end
         end
         PH_NUM: begin
            if (c < "0" || c > "9") begin
               emit(TK_NUMBER, tok_begin, off, ERR_OK, 1'b0);
               phase = PH_VALUE_END;
               scan_structure(c, off);
            end
         end
         PH_LIT: begin
            if (c != lit_byte(lit_kind, lit_idx)) raise_error(ERR_LITERAL, off);
            else begin
               lit_idx++;
               if (lit_idx == lit_len(lit_kind)) begin
                  emit(tok_type'(TK_TRUE + lit_kind), tok_begin, off + 1, ERR_OK, 1'b0);
                  phase = PH_VALUE_END;
               end
            end
         end
         default: scan_structure(c, off);
      endcase
      if (fin) begin
         if (phase == PH_NUM) emit(TK_NUMBER, tok_begin, off + 1, ERR_OK, 1'b0);
         if (phase != PH_END && phase != PH_ERR) begin
            while (step_toks.size() > 1) void'(step_toks.pop_back());
            emit(TK_OBJ_BEGIN, off, off + 1, ERR_EARLY, 1'b1);
         end
         clear_state();
      end else offset = off + 1;
      while (step_toks.size() > 2) void'(step_toks.pop_back());
      foreach (step_toks[i]) begin
         step_toks[i].last = (i == step_toks.size() - 1);
         token_q.push_back(step_toks[i]);
      end
   endfunction

   function automatic void clear_state();
      phase = PH_START;
      depth = 0;
      offset = '0;
      tok_begin = '0;
      lit_kind = '0;
      lit_idx = '0;
      is_key = 1'b0;
   endfunction

   initial begin
      fail_count = 0;
      clear_state();
   end

   always @(posedge clock) begin
      tok_rec_type got, want;
      if (reset) begin
         clear_state();
         token_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_token_kind, rsp_token_start, rsp_token_end, rsp_error_code,
                     rsp_doc_done, rsp_run_last};
            if (token_q.size() == 0) report("token beat with nothing expected");
            else begin
               want = token_q.pop_front();
               if (got.kind != want.kind)
                  report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
               if (got.start != want.start)
                  report($sformatf("start %0d, expected %0d", got.start, want.start));
               if (got.stop != want.stop)
                  report($sformatf("end %0d, expected %0d", got.stop, want.stop));
               if (got.err != want.err)
                  report($sformatf("error %0d, expected %0d", got.err, want.err));
               if (got.done != want.done)
                  report($sformatf("doc_done %0d, expected %0d", got.done, want.done));
               if (got.last != want.last)
                  report($sformatf("run_last %0d, expected %0d", got.last, want.last));
            end
         end
         if (req_valid && !req_stall) tokenize_byte(req_char_in, req_last_byte);
      end
   end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import jbt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [31:0] rsp_token_start;
   logic [31:0] rsp_token_end;
   logic [2:0]  rsp_error_code;
   logic        rsp_doc_done;
   logic        rsp_run_last;
   int          fail_count;
   int          pending_tokens;
   int          cycle_count = 0;
   int          idle_pct = 37;
   bit          hold_rsp = 1'b0;

   json_byte_tokenizer_top dut (.*);
   tb_checker checker_i (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= hold_rsp || ($urandom_range(99) < idle_pct);

   task automatic send_byte(input logic [7:0] c, input logic fin);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      req_last_byte <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_doc(input string s);
      foreach (s[i]) send_byte(s[i], i == s.len() - 1);
   endtask

   function automatic string rand_value(input int lvl);
      string s;
      int n;
      case ($urandom_range(lvl > 3 ? 4 : 7))
         0: s = "true";
         1: s = "false";
         2: s = "null";
         3: s = $sformatf("%0d", $urandom_range(99999));
         4: s = $sformatf("\"s%0d\"", $urandom_range(99));
         5, 6: begin
            s = "[";
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++)
               s = {s, (i ? ", " : ""), rand_value(lvl + 1)};
            s = {s, "]"};
         end
         default: begin
            s = "{";
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++)
               s = {s, (i ? "," : ""), $sformatf("\"k%0d\" : ", i), rand_value(lvl + 1)};
            s = {s, "}"};
         end
      endcase
      return s;
   endfunction

   function automatic string mangle(input string s);
      int p;
      p = $urandom_range(s.len() - 1);
      s[p] = 8'($urandom_range(255));
      return s;
   endfunction

   initial begin
      string d;
      int sent;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_doc("{\"a\":[1,true,false,null,\"x\"],\"b\":{}}");
      send_doc("[tru]");
      send_doc("{\"\":1}");
      send_doc("[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[1]]");
      send_doc("[1}");
      send_doc("[1,]");
      send_doc(" \t[\n12\r]  x");
      send_doc("[12");
      send_doc("[1,2");
      send_byte(8'hff, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte("]", 1'b1);
      idle_pct = 0;
      send_doc("[1,[2,3],{\"k\":\"v\"},false]");
      idle_pct = 37;
      hold_rsp <= 1'b1;
      fork
         begin
            repeat (40) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         send_doc("[1,2,3,4,5,6,7,8,9]");
      join
      sent = 0;
      while (sent < 490) begin
         d = rand_value(0);
         if ($urandom_range(99) < 75) d = {"[", d, "]"};
         else if ($urandom_range(1)) d = mangle({"{\"q\":", d, "}"});
         else begin
            d = "";
            repeat ($urandom_range(8, 1)) d = {d, 8'($urandom_range(255))};
         end
         send_doc(d);
         sent += d.len();
      end
      req_valid <= 1'b0;
      while (pending_tokens != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

[json_byte_tokenizer_top.f]
rtl/jbt_pkg.sv
rtl/jbt_front.sv
rtl/jbt_back.sv
rtl/json_byte_tokenizer_top.sv
sim/tb_checker.sv
sim/tb_top.sv
